// ===== sv/srr_pkg.sv =====
// Shared types and constants for the selective-repeat receiver.
// Holds the controller state encoding and the command and status bundles.
// No dependencies; compiled before every other file.
package srr_pkg;

   // Result kinds carried on the result channel.
   localparam logic KIND_DELIVER = 1'b0;
   localparam logic KIND_ACK     = 1'b1;

   // The window base starts at sequence number one after reset.
   localparam int BASE_RESET = 1;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STORE,
      ST_LOOK,
      ST_DATA,
      ST_ACK
   } srr_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;    // latch the arriving packet
      logic store;      // buffer the packet and update the ack number
      logic fetch;      // read the slot at the window base and release it
      logic load_data;  // put a delivery item in the output register
      logic load_ack;   // put the acknowledgement in the output register
   } srr_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pkt_in_window;  // captured packet is good and inside the window
      logic base_held;      // slot at the window base holds a payload
      logic out_free;       // output register can take an item this cycle
   } srr_status_type;

endpackage

// ===== sv/srr_req_if.sv =====
// Packet channel into the selective-repeat receiver.
// Carries valid, ready and the packet fields; no dependencies.
interface srr_req_if #(
   parameter int SEQ_BITS     = 4,
   parameter int PAYLOAD_BITS = 64
);
   logic                    valid;
   logic                    ready;
   logic [SEQ_BITS-1:0]     seq_num;
   logic [PAYLOAD_BITS-1:0] payload;
   logic                    checksum_ok;

   modport source (output valid, seq_num, payload, checksum_ok, input ready);
   modport sink   (input valid, seq_num, payload, checksum_ok, output ready);
endinterface

// ===== sv/srr_rsp_if.sv =====
// Result channel out of the selective-repeat receiver.
// Carries valid, ready and the delivery or acknowledgement fields; no dependencies.
interface srr_rsp_if #(
   parameter int SEQ_BITS     = 4,
   parameter int PAYLOAD_BITS = 64
);
   logic                    valid;
   logic                    ready;
   logic                    kind;
   logic [SEQ_BITS-1:0]     out_seq;
   logic [PAYLOAD_BITS-1:0] out_payload;
   logic                    last;

   modport source (output valid, kind, out_seq, out_payload, last, input ready);
   modport sink   (input valid, kind, out_seq, out_payload, last, output ready);
endinterface

// ===== sv/srr_ctrl.sv =====
// Controller state machine of the selective-repeat receiver.
// Sequences capture, buffering, in-order release and the acknowledgement.
// Depends on srr_pkg.
module srr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  srr_pkg::srr_status_type status,
   output srr_pkg::srr_cmd_type    cmd
);
   import srr_pkg::*;

   srr_state_type state_ff;
   srr_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            state_in  = status.pkt_in_window ? ST_LOOK : ST_ACK;
         end
         ST_LOOK: begin
            if (status.base_held) begin
               cmd.fetch = 1'b1;
               state_in  = ST_DATA;
            end else begin
               state_in = ST_ACK;
            end
         end
         ST_DATA: begin
            if (status.out_free) begin
               cmd.load_data = 1'b1;
               state_in      = ST_LOOK;
            end
         end
         ST_ACK: begin
            if (status.out_free) begin
               cmd.load_ack = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/srr_dpath.sv =====
// Datapath of the selective-repeat receiver: packet capture, receive buffer,
// hold flags, window base, last ack number and the output register.
// Depends on srr_pkg; driven by srr_ctrl through the command bundle.
module srr_dpath #(
   parameter int SEQ_BITS     = 4,
   parameter int WINDOW       = 8,
   parameter int PAYLOAD_BITS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [SEQ_BITS-1:0]     req_seq_num,
   input  logic [PAYLOAD_BITS-1:0] req_payload,
   input  logic                    req_checksum_ok,
   input  srr_pkg::srr_cmd_type    cmd,
   output srr_pkg::srr_status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_kind,
   output logic [SEQ_BITS-1:0]     rsp_out_seq,
   output logic [PAYLOAD_BITS-1:0] rsp_out_payload,
   output logic                    rsp_last
);
   import srr_pkg::*;

   localparam int SLOT_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int EXT_BITS  = (SEQ_BITS > SLOT_BITS) ? SEQ_BITS : SLOT_BITS;
   // Wide enough for any sequence offset and for the window size itself.
   localparam int CMP_BITS  = SEQ_BITS + 6;

   // Slot of a sequence number: the window size is a power of two.
   function automatic logic [SLOT_BITS-1:0] slot_of(input logic [SEQ_BITS-1:0] s);
      logic [EXT_BITS-1:0] ext;
      begin
         ext = EXT_BITS'(s) & EXT_BITS'(WINDOW - 1);
         return SLOT_BITS'(ext);
      end
   endfunction

   logic [SEQ_BITS-1:0]     seq_ff;
   logic [PAYLOAD_BITS-1:0] pay_ff;
   logic                    good_ff;
   logic [SEQ_BITS-1:0]     base_ff;
   logic [SEQ_BITS-1:0]     last_ack_ff;
   logic [WINDOW-1:0]       held_ff;
   logic [PAYLOAD_BITS-1:0] buf_mem [WINDOW];
   logic [PAYLOAD_BITS-1:0] rd_data_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_kind_ff;
   logic [SEQ_BITS-1:0]     rsp_seq_ff;
   logic [PAYLOAD_BITS-1:0] rsp_pay_ff;
   logic                    rsp_last_ff;

   logic [SEQ_BITS-1:0]  offset;
   logic                 in_window;
   logic [SLOT_BITS-1:0] seq_slot;
   logic [SLOT_BITS-1:0] base_slot;
   logic                 do_write;
   logic                 out_load;

   // Window test, slot selection and status to the controller.
   always_comb begin
      offset    = seq_ff - base_ff;
      in_window = CMP_BITS'(offset) < CMP_BITS'(WINDOW);
      seq_slot  = slot_of(seq_ff);
      base_slot = slot_of(base_ff);
      do_write  = cmd.store && good_ff && in_window && !held_ff[seq_slot];
      out_load  = cmd.load_data || cmd.load_ack;
      status.pkt_in_window = good_ff && in_window;
      status.base_held     = held_ff[base_slot];
      status.out_free      = !rsp_valid_ff || rsp_ready;
   end

   // Captured packet fields.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         seq_ff  <= req_seq_num;
         pay_ff  <= req_payload;
         good_ff <= req_checksum_ok;
      end
   end

   // Receive buffer: written when a new packet is held, read at the base slot.
   always_ff @(posedge clock) begin
      if (do_write) begin
         buf_mem[seq_slot] <= pay_ff;
      end
      if (cmd.fetch) begin
         rd_data_ff <= buf_mem[base_slot];
      end
   end

   // Hold flags, window base and last acknowledgement number.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff     <= '0;
         base_ff     <= SEQ_BITS'(BASE_RESET);
         last_ack_ff <= '0;
      end else begin
         if (do_write) begin
            held_ff[seq_slot] <= 1'b1;
         end
         if (cmd.fetch) begin
            held_ff[base_slot] <= 1'b0;
         end
         if (cmd.store && good_ff) begin
            last_ack_ff <= seq_ff;
         end
         if (cmd.load_data) begin
            base_ff <= base_ff + SEQ_BITS'(1);
         end
      end
   end

   // Output register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output register payload: a delivery or the acknowledgement.
   always_ff @(posedge clock) begin
      if (cmd.load_data) begin
         rsp_kind_ff <= KIND_DELIVER;
         rsp_seq_ff  <= base_ff;
         rsp_pay_ff  <= rd_data_ff;
         rsp_last_ff <= 1'b0;
      end else if (cmd.load_ack) begin
         rsp_kind_ff <= KIND_ACK;
         rsp_seq_ff  <= last_ack_ff;
         rsp_pay_ff  <= '0;
         rsp_last_ff <= 1'b1;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_out_seq     = rsp_seq_ff;
   assign rsp_out_payload = rsp_pay_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== sv/selective_repeat_receiver_unit.sv =====
// Top level of the selective-repeat ARQ receiver.
// Joins the controller (srr_ctrl) and the datapath (srr_dpath); uses srr_pkg,
// srr_req_if and srr_rsp_if.
//
//   Channel | Direction | Contents
//   --------+-----------+------------------------------------------------
//   req_if  | in        | seq_num, payload, checksum_ok of one packet
//   rsp_if  | out       | kind, out_seq, out_payload, last (deliveries, then ack)
//
// For a good packet inside the window, the controller steps through the held
// buffer slots from the window base; a corrupt or out-of-window packet goes
// straight to the ack. Each slot is read through the single read port of the
// buffer before it is loaded, and the next slot is checked only after that load.
// Reset clears the hold flags, sets the window base to one and the ack number
// to zero; the buffer itself needs no clearing. A stalled result holds the
// controller in place; the next packet is taken while the ack still waits.
module selective_repeat_receiver_unit #(
   parameter int SEQ_BITS     = 4,
   parameter int WINDOW       = 8,
   parameter int PAYLOAD_BITS = 64
) (
   input logic        clock,
   input logic        reset,
   srr_req_if.sink    req_if,
   srr_rsp_if.source  rsp_if
);
   import srr_pkg::*;

   srr_cmd_type    cmd;
   srr_status_type status;
   logic           req_ready;

   // Controller.
   srr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath.
   srr_dpath #(
      .SEQ_BITS     (SEQ_BITS),
      .WINDOW       (WINDOW),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_seq_num     (req_if.seq_num),
      .req_payload     (req_if.payload),
      .req_checksum_ok (req_if.checksum_ok),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_kind        (rsp_if.kind),
      .rsp_out_seq     (rsp_if.out_seq),
      .rsp_out_payload (rsp_if.out_payload),
      .rsp_last        (rsp_if.last)
   );

   assign req_if.ready = req_ready;

   // The output register is loaded only when it is free.
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_data || cmd.load_ack) |-> status.out_free)
      else $error("output register loaded while a result is still pending");

   // A slot is fetched only while it holds a payload.
   a_fetch_held: assert property (@(posedge clock) disable iff (reset)
      cmd.fetch |-> status.base_held)
      else $error("buffer slot fetched without a held payload");

   // An accepted packet blocks the channel until its ack has been queued.
   a_one_packet: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("second packet accepted before the first finished");

   // Loading the ack shows a valid result flagged as the last one.
   a_ack_last: assert property (@(posedge clock) disable iff (reset)
      cmd.load_ack |=> (rsp_if.valid && rsp_if.last && rsp_if.kind == KIND_ACK))
      else $error("acknowledgement not presented as the final result");

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for the selective-repeat receiver top level.
// Uses srr_pkg, srr_req_if and srr_rsp_if; drives packets, mirrors the receive
// window in its own state, and checks every delivery and acknowledgement.
module tb_top;
   import srr_pkg::*;

   localparam int SEQ_BITS     = 4;
   localparam int WINDOW       = 8;
   localparam int PAYLOAD_BITS = 64;

   typedef logic [SEQ_BITS-1:0]     seq_t;
   typedef logic [PAYLOAD_BITS-1:0] word_t;

   typedef struct {
      seq_t  seq_num;
      word_t payload;
      logic  checksum_ok;
      bit    drain_first;  // hold this packet back until all results are in
   } packet_t;

   typedef struct {
      logic  kind;
      seq_t  out_seq;
      word_t out_payload;
      logic  last;
   } result_t;

   logic clock;
   logic reset;

   srr_req_if #(.SEQ_BITS(SEQ_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)) req_if ();
   srr_rsp_if #(.SEQ_BITS(SEQ_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)) rsp_if ();

   selective_repeat_receiver_unit #(
      .SEQ_BITS(SEQ_BITS),
      .WINDOW(WINDOW),
      .PAYLOAD_BITS(PAYLOAD_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   // Mirror of the receiver: window base, hold flags, buffered words, ack number.
   seq_t    rx_base;
   bit      rx_held [WINDOW];
   word_t   rx_word [WINDOW];
   seq_t    rx_ack;

   packet_t outbound_packets[$];
   result_t due_results[$];
   int      total_packets;
   int      accepted_count;
   int      fail_count;

   // Driver and monitor pacing.
   int      req_gap;
   bit      req_calm;
   int      rsp_gap;
   bit      rsp_calm;
   packet_t next_pkt;
   result_t got;
   result_t want;

   // Clock with a period of 10.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Count a mismatch and print one line for it.
   task automatic report_mismatch(input string what);
      fail_count++;
      $display("mismatch: %s", what);
   endtask

   // Idle cycles before the next item on either side; calm stretches draw none.
   function automatic int idle_draw(input bit calm);
      return calm ? 0 : $urandom_range(0, 8);
   endfunction

   // Apply one accepted packet to the mirror and queue the results it releases.
   task automatic absorb_packet(input seq_t seq, input word_t pay, input logic ok);
      seq_t    offset;
      int      slot;
      int      n;
      result_t r;
      n = 0;
      if (ok) begin
         offset = seq - rx_base;
         if (int'(offset) < WINDOW) begin
            slot = int'(seq) % WINDOW;
            // A duplicate keeps the word that was buffered first.
            if (!rx_held[slot]) begin
               rx_held[slot] = 1'b1;
               rx_word[slot] = pay;
            end
            // Release the run of held slots starting at the base.
            while (n < WINDOW && rx_held[int'(rx_base) % WINDOW]) begin
               slot = int'(rx_base) % WINDOW;
               rx_held[slot] = 1'b0;
               r.kind        = KIND_DELIVER;
               r.out_seq     = rx_base;
               r.out_payload = rx_word[slot];
               r.last        = 1'b0;
               due_results.push_back(r);
               n++;
               rx_base = rx_base + 1'b1;
            end
         end
         rx_ack = seq;
      end
      // Every packet ends with an ack; a corrupt one repeats the previous number.
      r.kind        = KIND_ACK;
      r.out_seq     = rx_ack;
      r.out_payload = '0;
      r.last        = 1'b1;
      due_results.push_back(r);
   endtask

   task automatic add_packet(input seq_t seq, input word_t pay, input logic ok,
                             input bit drain);
      packet_t p;
      p.seq_num     = seq;
      p.payload     = pay;
      p.checksum_ok = ok;
      p.drain_first = drain;
      outbound_packets.push_back(p);
   endtask

   function automatic word_t rand_word();
      return {$urandom, $urandom};
   endfunction

   // Packet driver: presents the queued packets with random gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap      = 0;
         req_calm     = 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            absorb_packet(req_if.seq_num, req_if.payload, req_if.checksum_ok);
            accepted_count++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (req_gap > 0) begin
               req_gap = req_gap - 1;
               req_if.valid <= 1'b0;
            end else if (outbound_packets.size() > 0 &&
                         !(outbound_packets[0].drain_first && due_results.size() != 0)) begin
               next_pkt = outbound_packets.pop_front();
               req_if.valid       <= 1'b1;
               req_if.seq_num     <= next_pkt.seq_num;
               req_if.payload     <= next_pkt.payload;
               req_if.checksum_ok <= next_pkt.checksum_ok;
               if ($urandom_range(0, 9) == 0) begin
                  req_calm = !req_calm;
               end
               req_gap = idle_draw(req_calm);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: stalls at random and checks each item against the oldest due one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_gap      = 0;
         rsp_calm     = 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.kind        = rsp_if.kind;
            got.out_seq     = rsp_if.out_seq;
            got.out_payload = rsp_if.out_payload;
            got.last        = rsp_if.last;
            if (due_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result kind %0d seq %0d",
                                         got.kind, got.out_seq));
            end else begin
               want = due_results.pop_front();
               if (got.kind !== want.kind) begin
                  report_mismatch($sformatf("kind got %0d want %0d", got.kind, want.kind));
               end
               if (got.out_seq !== want.out_seq) begin
                  report_mismatch($sformatf("out_seq got %0d want %0d",
                                            got.out_seq, want.out_seq));
               end
               if (got.out_payload !== want.out_payload) begin
                  report_mismatch($sformatf("out_payload got %h want %h",
                                            got.out_payload, want.out_payload));
               end
               if (got.last !== want.last) begin
                  report_mismatch($sformatf("last got %0d want %0d", got.last, want.last));
               end
            end
            if ($urandom_range(0, 9) == 0) begin
               rsp_calm = !rsp_calm;
            end
            rsp_gap = idle_draw(rsp_calm);
            rsp_if.ready <= (rsp_gap == 0);
         end else if (rsp_gap > 0) begin
            rsp_gap = rsp_gap - 1;
            rsp_if.ready <= (rsp_gap == 0);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      seq_t  burst [WINDOW];
      seq_t  gen_base;
      seq_t  tmp;
      int    j;
      int    pick;
      clock              = 1'b0;
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.seq_num     = '0;
      req_if.payload     = '0;
      req_if.checksum_ok = 1'b0;
      rsp_if.ready       = 1'b0;
      accepted_count     = 0;
      fail_count         = 0;
      rx_base            = seq_t'(BASE_RESET);
      rx_ack             = '0;
      for (int i = 0; i < WINDOW; i++) begin
         rx_held[i] = 1'b0;
         rx_word[i] = '0;
      end

      // Directed part; the base starts at one.
      add_packet(4'd5, '1, 1'b0, 1'b0);               // corrupt before any ack
      add_packet(4'd0, rand_word(), 1'b1, 1'b0);      // just below the window
      add_packet(4'd15, rand_word(), 1'b1, 1'b0);     // out of window, top seq
      add_packet(4'd3, '0, 1'b1, 1'b0);               // buffered, zero word
      add_packet(4'd3, '1, 1'b1, 1'b0);               // duplicate keeps zero word
      add_packet(4'd5, rand_word(), 1'b0, 1'b0);      // corrupt repeats ack 3
      add_packet(4'd8, '1, 1'b1, 1'b0);               // last slot of the window
      add_packet(4'd9, rand_word(), 1'b1, 1'b0);      // one past the window
      add_packet(4'd2, rand_word(), 1'b1, 1'b0);
      add_packet(4'd4, rand_word(), 1'b1, 1'b0);
      add_packet(4'd5, rand_word(), 1'b1, 1'b0);
      add_packet(4'd6, rand_word(), 1'b1, 1'b0);
      add_packet(4'd7, rand_word(), 1'b1, 1'b0);
      add_packet(4'd1, rand_word(), 1'b1, 1'b0);      // releases a full window
      add_packet(4'd12, rand_word(), 1'b0, 1'b1);     // corrupt after a drain

      // Random part: each burst covers the next window in shuffled order,
      // with corrupt packets, stale packets and duplicates mixed in.
      gen_base = 4'd9;
      for (int b = 0; b < 14; b++) begin
         for (int i = 0; i < WINDOW; i++) begin
            burst[i] = gen_base + seq_t'(i);
         end
         for (int i = WINDOW - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = burst[i];
            burst[i] = burst[j];
            burst[j] = tmp;
         end
         for (int i = 0; i < WINDOW; i++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               add_packet(seq_t'($urandom), rand_word(), 1'b0, 1'b0);
            end else if (pick == 1) begin
               add_packet(gen_base - 1'b1 - seq_t'($urandom_range(0, WINDOW - 1)),
                          rand_word(), 1'b1, 1'b0);
            end else if (pick == 2 && i > 0) begin
               add_packet(burst[$urandom_range(0, i - 1)], rand_word(), 1'b1, 1'b0);
            end
            add_packet(burst[i], rand_word(), 1'b1,
                       (b == 0 && i == 0) || ($urandom_range(0, 19) == 0));
         end
         gen_base = gen_base + seq_t'(WINDOW);
      end
      total_packets = outbound_packets.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_packets) @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (due_results.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", due_results.size()));
      end
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog for a stuck handshake.
   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/srr_pkg.sv
sv/srr_req_if.sv
sv/srr_rsp_if.sv
sv/srr_ctrl.sv
sv/srr_dpath.sv
sv/selective_repeat_receiver_unit.sv
test/tb_top.sv
